/* hw/rtl/lpg_pkg.sv */
// Package for the fixed-point line pixel generator.
// Holds the fixed field widths, the stride reset value and the per-line flag bundle.
// No dependencies.

package lpg_pkg;

	localparam int COLOR_W  = 8;
	localparam int ADDR_W   = 21;
	localparam int STRIDE_W = 12;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 12'd640;

	// Per-line control bits that ride along with the pixel through the pipeline.
	typedef struct packed {
		logic x_major;   // x is the major axis
		logic major_neg; // major axis runs toward smaller coordinates
		logic minor_neg; // minor delta is negative
		logic in_line;   // pixel index lies below the run length
		logic last;      // pixel index is the last one of the line
	} line_flags_t;

endpackage

/* hw/rtl/lpg_setup.sv */
// Line setup stage: deltas, major axis, run length and divider seed.
// Uses lpg_pkg for the flag bundle and field widths.

module lpg_setup #(
	parameter int COORD_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [COORD_BITS-1:0]       start_x,
	input  logic [COORD_BITS-1:0]       start_y,
	input  logic [COORD_BITS-1:0]       end_x,
	input  logic [COORD_BITS-1:0]       end_y,
	input  logic [lpg_pkg::COLOR_W-1:0] color,
	input  logic [COORD_BITS-1:0]       pixel_index,
	output logic                        valid_s1,
	output logic [COORD_BITS:0]         rem_s1,
	output logic                        lsb_s1,
	output logic [COORD_BITS:0]         run_s1,
	output logic [COORD_BITS-1:0]       sx_s1,
	output logic [COORD_BITS-1:0]       sy_s1,
	output logic [COORD_BITS-1:0]       idx_s1,
	output logic [lpg_pkg::COLOR_W-1:0] color_s1,
	output lpg_pkg::line_flags_t        flags_s1
);

	localparam int C = COORD_BITS;

	logic [C:0]   dx, dy, dx_abs, dy_abs;
	logic [C-1:0] adx, ady, major_abs, minor_abs;
	logic         x_major;
	logic [C:0]   run, num_mag;
	lpg_pkg::line_flags_t flags;

	always_comb begin
		dx     = {1'b0, end_x} - {1'b0, start_x};
		dy     = {1'b0, end_y} - {1'b0, start_y};
		dx_abs = dx[C] ? -dx : dx;
		dy_abs = dy[C] ? -dy : dy;
		adx    = dx_abs[C-1:0];
		ady    = dy_abs[C-1:0];
		x_major   = (adx >= ady);
		major_abs = x_major ? adx : ady;
		minor_abs = x_major ? ady : adx;
		run       = {1'b0, major_abs} + {{C{1'b0}}, 1'b1};
		// Magnitude of the minor delta plus one, the dividend before the fraction shift.
		num_mag   = {1'b0, minor_abs} + {{C{1'b0}}, 1'b1};
		flags.x_major   = x_major;
		flags.major_neg = x_major ? dx[C] : dy[C];
		flags.minor_neg = x_major ? dy[C] : dx[C];
		flags.in_line   = ({1'b0, pixel_index} < run);
		flags.last      = (pixel_index == major_abs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			// The seed is below the divisor because the dividend never exceeds the run.
			rem_s1   <= num_mag >> 1;
			lsb_s1   <= num_mag[0];
			run_s1   <= run;
			sx_s1    <= start_x;
			sy_s1    <= start_y;
			idx_s1   <= pixel_index;
			color_s1 <= color;
			flags_s1 <= flags;
		end
	end

endmodule

/* hw/rtl/lpg_div_cell.sv */
// One cell of the restoring divider chain: produces one quotient bit per cell.
// Carries the divisor and a side vector along to the next cell. No package use.

module lpg_div_cell #(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 10,
	parameter int SIDE_W     = 43
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  valid_in,
	input  logic [COORD_BITS:0]   rem_in,
	input  logic                  lsb_in,
	input  logic [COORD_BITS:0]   run_in,
	input  logic [FRAC_BITS:0]    q_in,
	input  logic [SIDE_W-1:0]     side_in,
	output logic                  valid_q,
	output logic [COORD_BITS:0]   rem_q,
	output logic [COORD_BITS:0]   run_q,
	output logic [FRAC_BITS:0]    q_q,
	output logic [SIDE_W-1:0]     side_q
);

	localparam int C = COORD_BITS;
	localparam int F = FRAC_BITS;

	logic [C+1:0] rem_sh, rem_sub;
	logic         take;

	always_comb begin
		rem_sh  = {rem_in, lsb_in};
		take    = (rem_sh >= {1'b0, run_in});
		rem_sub = take ? (rem_sh - {1'b0, run_in}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_in) begin
			rem_q  <= rem_sub[C:0];
			run_q  <= run_in;
			q_q    <= {q_in[F-1:0], take};
			side_q <= side_in;
		end
	end

endmodule

/* hw/rtl/lpg_coord.sv */
// Back end: step products, saturated coordinates and the framebuffer address.
// Uses lpg_pkg for field widths and the flag bundle.

module lpg_coord #(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid_in,
	input  logic [FRAC_BITS:0]           q_in,
	input  logic [COORD_BITS-1:0]        sx,
	input  logic [COORD_BITS-1:0]        sy,
	input  logic [COORD_BITS-1:0]        idx,
	input  logic [lpg_pkg::COLOR_W-1:0]  color,
	input  lpg_pkg::line_flags_t         flags,
	input  logic [lpg_pkg::STRIDE_W-1:0] stride,
	output logic                         valid_out,
	output logic [COORD_BITS-1:0]        x_out,
	output logic [COORD_BITS-1:0]        y_out,
	output logic [lpg_pkg::ADDR_W-1:0]   addr_out,
	output logic [lpg_pkg::COLOR_W-1:0]  color_out,
	output logic                         in_line_out,
	output logic                         last_out
);

	localparam int C      = COORD_BITS;
	localparam int F      = FRAC_BITS;
	localparam int PROD_W = C + F + 1;
	localparam int POS_W  = C + F + 3;
	localparam int AP_W   = C + lpg_pkg::STRIDE_W;
	localparam int SUM_W  = (AP_W + 1 > lpg_pkg::ADDR_W) ? AP_W + 1 : lpg_pkg::ADDR_W;
	localparam logic [C+1:0] COORD_MAX = (C+2)'((1 << C) - 1);

	// Position start * 2^F plus or minus the product, floored and clamped to the range.
	function automatic logic [C-1:0] to_coord(input logic [C-1:0] s,
			input logic [PROD_W-1:0] prod, input logic neg);
		logic [POS_W-1:0] base, mag, pos;
		logic [C+1:0]     whole;
		base  = POS_W'(s) << F;
		mag   = POS_W'(prod);
		pos   = neg ? (base - mag) : (base + mag);
		whole = pos[POS_W-2:F];
		if (pos[POS_W-1]) begin
			return '0;
		end else if (whole > COORD_MAX) begin
			return COORD_MAX[C-1:0];
		end
		return whole[C-1:0];
	endfunction

	logic [PROD_W-1:0] prod_minor, prod_major;

	logic                        valid_s1, valid_s2, valid_s3;
	logic [PROD_W-1:0]           xprod_s1, yprod_s1;
	logic                        xneg_s1, yneg_s1;
	logic [C-1:0]                sx_s1, sy_s1;
	logic [lpg_pkg::COLOR_W-1:0] color_s1, color_s2, color_s3;
	logic                        in_line_s1, in_line_s2, in_line_s3;
	logic                        last_s1, last_s2, last_s3;
	logic [C-1:0]                px_s2, py_s2, px_s3;
	logic [AP_W-1:0]             aprod_s3;
	logic [SUM_W-1:0]            addr_sum;

	always_comb begin
		prod_minor = PROD_W'(idx) * PROD_W'(q_in);
		prod_major = PROD_W'({idx, {F{1'b0}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_in) begin
			xprod_s1   <= flags.x_major ? prod_major : prod_minor;
			yprod_s1   <= flags.x_major ? prod_minor : prod_major;
			xneg_s1    <= flags.x_major ? flags.major_neg : flags.minor_neg;
			yneg_s1    <= flags.x_major ? flags.minor_neg : flags.major_neg;
			sx_s1      <= sx;
			sy_s1      <= sy;
			color_s1   <= color;
			in_line_s1 <= flags.in_line;
			last_s1    <= flags.last;
		end
		if (en && valid_s1) begin
			px_s2      <= to_coord(sx_s1, xprod_s1, xneg_s1);
			py_s2      <= to_coord(sy_s1, yprod_s1, yneg_s1);
			color_s2   <= color_s1;
			in_line_s2 <= in_line_s1;
			last_s2    <= last_s1;
		end
		if (en && valid_s2) begin
			aprod_s3   <= AP_W'(py_s2) * AP_W'(stride);
			px_s3      <= px_s2;
			color_s3   <= color_s2;
			in_line_s3 <= in_line_s2;
			last_s3    <= last_s2;
		end
	end

	// The row index is needed again next to the address product.
	logic [C-1:0] py_s3;
	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			py_s3 <= py_s2;
		end
	end

	always_comb begin
		addr_sum    = SUM_W'(aprod_s3) + SUM_W'(px_s3);
		valid_out   = valid_s3;
		// Pixels past the end of the line come out as all zeros.
		x_out       = in_line_s3 ? px_s3 : '0;
		y_out       = in_line_s3 ? py_s3 : '0;
		addr_out    = in_line_s3 ? addr_sum[lpg_pkg::ADDR_W-1:0] : '0;
		color_out   = in_line_s3 ? color_s3 : '0;
		in_line_out = in_line_s3;
		last_out    = in_line_s3 & last_s3;
	end

endmodule

/* hw/rtl/fixed_point_line_pixel_generator_core.sv */
// Top level of the fixed-point line pixel generator: setup, divider cell chain,
// coordinate back end and output skid. Uses lpg_pkg, lpg_setup, lpg_div_cell, lpg_coord.
//
//  channel   direction  handshake            beat contents
//  input     in         in_valid / in_stall  start_x start_y end_x end_y color pixel_index
//  output    out        out_valid / out_stall pixel_x pixel_y pixel_address pixel_color
//                                            pixel_valid last_pixel
//  config    in         cfg_valid / cfg_ready frame_stride
//
// One beat is accepted per cycle while in_stall is low.
// The divider chain has one cell per quotient bit (FRAC_BITS + 1 cells).
// Reset clears all valid bits and loads frame_stride with 640; no clearing pass is needed.
// A stalled output beat holds; the next beat parks in a skid register, and only when
// that register is full does in_stall rise and the whole pipeline freeze.

module fixed_point_line_pixel_generator_core #(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lpg_pkg::STRIDE_W-1:0] frame_stride,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [COORD_BITS-1:0]        start_x,
	input  logic [COORD_BITS-1:0]        start_y,
	input  logic [COORD_BITS-1:0]        end_x,
	input  logic [COORD_BITS-1:0]        end_y,
	input  logic [lpg_pkg::COLOR_W-1:0]  color,
	input  logic [COORD_BITS-1:0]        pixel_index,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [COORD_BITS-1:0]        pixel_x,
	output logic [COORD_BITS-1:0]        pixel_y,
	output logic [lpg_pkg::ADDR_W-1:0]   pixel_address,
	output logic [lpg_pkg::COLOR_W-1:0]  pixel_color,
	output logic                         pixel_valid,
	output logic                         last_pixel
);

	localparam int C       = COORD_BITS;
	localparam int F       = FRAC_BITS;
	localparam int NCELL   = F + 1;
	localparam int FLAGS_W = $bits(lpg_pkg::line_flags_t);
	localparam int SIDE_W  = FLAGS_W + lpg_pkg::COLOR_W + 3 * C;
	localparam int OUT_W   = 2 * C + lpg_pkg::ADDR_W + lpg_pkg::COLOR_W + 2;

	logic [lpg_pkg::STRIDE_W-1:0] stride_q;
	logic                         en;

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= lpg_pkg::STRIDE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			stride_q <= frame_stride;
		end
	end

	// Setup stage.
	logic                        setup_valid, setup_lsb;
	logic [C:0]                  setup_rem, setup_run;
	logic [C-1:0]                setup_sx, setup_sy, setup_idx;
	logic [lpg_pkg::COLOR_W-1:0] setup_color;
	lpg_pkg::line_flags_t        setup_flags;

	lpg_setup #(
		.COORD_BITS(C)
	) u_setup (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.color      (color),
		.pixel_index(pixel_index),
		.valid_s1   (setup_valid),
		.rem_s1     (setup_rem),
		.lsb_s1     (setup_lsb),
		.run_s1     (setup_run),
		.sx_s1      (setup_sx),
		.sy_s1      (setup_sy),
		.idx_s1     (setup_idx),
		.color_s1   (setup_color),
		.flags_s1   (setup_flags)
	);

	// Divider cell chain; entry 0 is the setup output.
	logic              chain_valid [0:NCELL];
	logic [C:0]        chain_rem   [0:NCELL];
	logic [C:0]        chain_run   [0:NCELL];
	logic [F:0]        chain_q     [0:NCELL];
	logic [SIDE_W-1:0] chain_side  [0:NCELL];

	assign chain_valid[0] = setup_valid;
	assign chain_rem[0]   = setup_rem;
	assign chain_run[0]   = setup_run;
	assign chain_q[0]     = '0;
	assign chain_side[0]  = {setup_flags, setup_color, setup_idx, setup_sy, setup_sx};

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		lpg_div_cell #(
			.COORD_BITS(C),
			.FRAC_BITS (F),
			.SIDE_W    (SIDE_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_in(chain_valid[i]),
			.rem_in  (chain_rem[i]),
			// Only the first cell brings down a dividend bit; the rest shift in zeros.
			.lsb_in  ((i == 0) ? setup_lsb : 1'b0),
			.run_in  (chain_run[i]),
			.q_in    (chain_q[i]),
			.side_in (chain_side[i]),
			.valid_q (chain_valid[i+1]),
			.rem_q   (chain_rem[i+1]),
			.run_q   (chain_run[i+1]),
			.q_q     (chain_q[i+1]),
			.side_q  (chain_side[i+1])
		);
	end

	// Coordinate and address back end.
	lpg_pkg::line_flags_t        tail_flags;
	logic [lpg_pkg::COLOR_W-1:0] tail_color_in;
	logic [C-1:0]                tail_idx, tail_sy, tail_sx;

	assign {tail_flags, tail_color_in, tail_idx, tail_sy, tail_sx} = chain_side[NCELL];

	logic                        tail_valid, tail_in_line, tail_last;
	logic [C-1:0]                tail_x, tail_y;
	logic [lpg_pkg::ADDR_W-1:0]  tail_addr;
	logic [lpg_pkg::COLOR_W-1:0] tail_color;

	lpg_coord #(
		.COORD_BITS(C),
		.FRAC_BITS (F)
	) u_coord (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid_in   (chain_valid[NCELL]),
		.q_in       (chain_q[NCELL]),
		.sx         (tail_sx),
		.sy         (tail_sy),
		.idx        (tail_idx),
		.color      (tail_color_in),
		.flags      (tail_flags),
		.stride     (stride_q),
		.valid_out  (tail_valid),
		.x_out      (tail_x),
		.y_out      (tail_y),
		.addr_out   (tail_addr),
		.color_out  (tail_color),
		.in_line_out(tail_in_line),
		.last_out   (tail_last)
	);

	// Output register and skid register.
	logic [OUT_W-1:0] tail_data, out_data_q, skid_data_q;
	logic             out_valid_q, skid_valid_q;

	assign tail_data = {tail_x, tail_y, tail_addr, tail_color, tail_in_line, tail_last};
	assign en        = !skid_valid_q;
	assign in_stall  = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!out_stall) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= tail_valid;
		end else if (tail_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!out_stall) begin
				out_data_q <= skid_data_q;
			end
		end else if (!out_valid_q || !out_stall) begin
			out_data_q <= tail_data;
		end else if (tail_valid) begin
			skid_data_q <= tail_data;
		end
	end

	assign out_valid = out_valid_q;
	assign {pixel_x, pixel_y, pixel_address, pixel_color, pixel_valid, last_pixel} = out_data_q;

	// The skid register only holds a beat while the output register is also full.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");

	// The skid register fills only on a cycle in which the output beat was stalled.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid register filled without an output stall");

	// A pixel off the end of the line carries all-zero fields.
	a_off_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !pixel_valid) |-> (pixel_x == '0 && pixel_y == '0 &&
			pixel_address == '0 && pixel_color == '0 && !last_pixel))
		else $error("off-line pixel with nonzero fields");

	// The divider remainder must stay below the run at the end of the chain.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[NCELL] |-> (chain_rem[NCELL] < chain_run[NCELL]))
		else $error("divider remainder not below divisor");

endmodule
